/* hw/rtl/efp_pkg.sv */
// Shared types and constants for the packed fuse map decoder.
`default_nettype none

package efp_pkg;

    // Configuration register indexes
    localparam logic CFG_TARGET_OFFSET = 1'b0;
    localparam logic CFG_PHYS_LIMIT    = 1'b1;

    localparam logic [9:0]  TARGET_RESET = 10'd202;
    localparam logic [10:0] LIMIT_RESET  = 11'd1024;
    localparam logic [10:0] COUNT_MAX    = 11'd2047;

    // End cause codes
    localparam logic [2:0] END_RUNNING   = 3'd0;
    localparam logic [2:0] END_BLANK     = 3'd1;
    localparam logic [2:0] END_PAST_TGT  = 3'd2;
    localparam logic [2:0] END_LIMIT     = 3'd3;
    localparam logic [2:0] END_HDR_FAIL  = 3'd4;
    localparam logic [2:0] END_DATA_FAIL = 3'd5;

    localparam logic [7:0] BLANK_HEADER = 8'hFF;
    localparam logic [4:0] EXT_MARK     = 5'h0F;
    localparam logic [3:0] MASK_ALL     = 4'hF;

    typedef struct packed {
        logic [9:0]  target_offset;
        logic [10:0] phys_limit;
    } t_cfg;

    typedef struct packed {
        logic       req_type;
        logic [7:0] byte_value;
        logic       read_ok;
    } t_in_item;

    typedef struct packed {
        logic       write_valid;
        logic [9:0] logical_addr;
        logic [7:0] write_data;
        logic       done_res;
        logic [7:0] target_value;
        logic [2:0] end_cause;
    } t_result;

endpackage

`default_nettype wire

/* hw/rtl/efuse_packed_map_decoder.sv */
// Top level: input register, configuration registers, decoder and result register.
// A request accepted into the input register is loaded into the result register when it
// steps, and from there it can be taken from m_axis.
// Throughput: one fuse byte per cycle; the input register loads whenever it is empty or
// stepping, and it steps whenever the result register is empty or being taken.
// Reset (synchronous, active low) empties both registers, sets target_offset to 202,
// phys_limit to 1024 and the decoder to expect a header.
`default_nettype none

module efuse_packed_map_decoder #(
    parameter int MAP_BYTES = 320
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Configuration write channel
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic        i_cfg_index,
    input  wire logic [10:0] i_cfg_data,
    // Input stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,  // [7:0] byte_value
    input  wire logic [1:0]  s_axis_tuser,  // [0] req_type, [1] read_ok
    // Result stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,  // [9:0] logical_addr, [17:10] write_data,
                                            // [25:18] target_value, [28:26] end_cause
    output logic [1:0]       m_axis_tuser   // [0] write_valid, [1] done_res
);

    efp_pkg::t_cfg     r_cfg;
    efp_pkg::t_in_item r_in;
    logic              r_in_valid;
    efp_pkg::t_result  r_out;
    logic              r_out_valid;
    efp_pkg::t_result  w_result;
    logic              w_out_free;
    logic              w_step;

    assign o_cfg_ready   = 1'b1;
    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_step        = r_in_valid && w_out_free;
    assign s_axis_tready = !r_in_valid || w_out_free;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.target_offset <= efp_pkg::TARGET_RESET;
            r_cfg.phys_limit    <= efp_pkg::LIMIT_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                efp_pkg::CFG_TARGET_OFFSET: r_cfg.target_offset <= i_cfg_data[9:0];
                efp_pkg::CFG_PHYS_LIMIT:    r_cfg.phys_limit    <= i_cfg_data;
                default:                    r_cfg               <= r_cfg;
            endcase
        end
    end

    // Capture a request into the input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (w_step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in.req_type   <= s_axis_tuser[0];
            r_in.byte_value <= s_axis_tdata;
            r_in.read_ok    <= s_axis_tuser[1];
        end
    end

    efp_decode_core #(
        .MAP_BYTES (MAP_BYTES)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_step),
        .i_cfg    (r_cfg),
        .i_item   (r_in),
        .o_result (w_result)
    );

    // Hold the result until the downstream side takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out <= w_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = {r_out.done_res, r_out.write_valid};
    assign m_axis_tdata  = {3'b000, r_out.end_cause, r_out.target_value,
                            r_out.write_data, r_out.logical_addr};

endmodule

`default_nettype wire

/* hw/rtl/efp_decode_core.sv */
// Section decoder: header, extension and data tracking with per-request result.
`default_nettype none

module efp_decode_core #(
    parameter int MAP_BYTES = 320
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_step,
    input  wire efp_pkg::t_cfg    i_cfg,
    input  wire efp_pkg::t_in_item i_item,
    output efp_pkg::t_result      o_result
);

    typedef enum logic [1:0] {
        PH_HDR,
        PH_EXT,
        PH_DATA,
        PH_DONE
    } t_phase;

    localparam logic [10:0] MAP_LIMIT = 11'(MAP_BYTES);

    // First word at or above from with a clear enable bit; 4 if none
    function automatic logic [2:0] next_clear(input logic [3:0] mask, input logic [2:0] from);
        logic [2:0] found;
        found = 3'd4;
        for (int i = 3; i >= 0; i--) begin
            if ((3'(i) >= from) && !mask[i]) begin
                found = 3'(i);
            end
        end
        return found;
    endfunction

    t_phase      r_phase, n_phase;
    logic [2:0]  r_hdr_hi, n_hdr_hi;
    logic [6:0]  r_offset, n_offset;
    logic [3:0]  r_mask, n_mask;
    logic [1:0]  r_widx, n_widx;
    logic        r_byte, n_byte;
    logic [10:0] r_count, n_count;
    logic [7:0]  r_capt, n_capt;
    logic [2:0]  r_end, n_end;

    logic        w_start;
    logic [6:0]  w_sec_off;
    logic [3:0]  w_sec_mask;
    logic        w_sec_end;
    logic [2:0]  w_next;
    logic [9:0]  w_addr;

    assign w_addr = {r_offset, r_widx, r_byte};

    always_comb begin
        n_phase    = r_phase;
        n_hdr_hi   = r_hdr_hi;
        n_offset   = r_offset;
        n_mask     = r_mask;
        n_widx     = r_widx;
        n_byte     = r_byte;
        n_count    = r_count;
        n_capt     = r_capt;
        n_end      = r_end;
        w_start    = 1'b0;
        w_sec_off  = '0;
        w_sec_mask = '0;
        w_sec_end  = 1'b0;
        w_next     = '0;
        o_result   = '0;

        if (i_item.req_type) begin
            // Restart: clear decode state, keep configuration
            n_phase  = PH_HDR;
            n_hdr_hi = '0;
            n_offset = '0;
            n_mask   = '0;
            n_widx   = '0;
            n_byte   = 1'b0;
            n_count  = '0;
            n_capt   = 8'hFF;
            n_end    = efp_pkg::END_RUNNING;
        end else if (r_phase != PH_DONE) begin
            if (r_phase == PH_HDR && r_count >= i_cfg.phys_limit) begin
                n_phase = PH_DONE;
                n_end   = efp_pkg::END_LIMIT;
            end else begin
                if (r_count < efp_pkg::COUNT_MAX) begin
                    n_count = r_count + 11'd1;
                end
                unique case (r_phase)
                    PH_EXT: begin
                        if (!i_item.read_ok) begin
                            n_phase = PH_DONE;
                            n_end   = efp_pkg::END_HDR_FAIL;
                        end else if (i_item.byte_value[3:0] == efp_pkg::MASK_ALL) begin
                            // Skipped extension: no base, no data
                            if (n_count >= i_cfg.phys_limit) begin
                                n_phase = PH_DONE;
                                n_end   = efp_pkg::END_LIMIT;
                            end else begin
                                n_phase = PH_HDR;
                            end
                        end else begin
                            w_start    = 1'b1;
                            w_sec_off  = {i_item.byte_value[7:4], r_hdr_hi};
                            w_sec_mask = i_item.byte_value[3:0];
                        end
                    end
                    PH_DATA: begin
                        if (!i_item.read_ok) begin
                            n_capt  = 8'h00;
                            n_phase = PH_DONE;
                            n_end   = efp_pkg::END_DATA_FAIL;
                        end else begin
                            if ({1'b0, w_addr} < MAP_LIMIT) begin
                                o_result.write_valid  = 1'b1;
                                o_result.logical_addr = w_addr;
                                o_result.write_data   = i_item.byte_value;
                                if (w_addr == i_cfg.target_offset) begin
                                    n_capt = i_item.byte_value;
                                end
                            end
                            if (!r_byte) begin
                                n_byte = 1'b1;
                            end else begin
                                n_byte = 1'b0;
                                w_next = next_clear(r_mask, {1'b0, r_widx} + 3'd1);
                                if (w_next[2]) begin
                                    n_widx    = '0;
                                    w_sec_end = 1'b1;
                                end else begin
                                    n_widx = w_next[1:0];
                                end
                            end
                        end
                    end
                    PH_HDR: begin
                        if (!i_item.read_ok) begin
                            n_phase = PH_DONE;
                            n_end   = efp_pkg::END_HDR_FAIL;
                        end else if (i_item.byte_value == efp_pkg::BLANK_HEADER) begin
                            n_phase = PH_DONE;
                            n_end   = efp_pkg::END_BLANK;
                        end else if (i_item.byte_value[4:0] == efp_pkg::EXT_MARK) begin
                            n_hdr_hi = i_item.byte_value[7:5];
                            n_phase  = PH_EXT;
                        end else begin
                            w_start    = 1'b1;
                            w_sec_off  = {3'b000, i_item.byte_value[7:4]};
                            w_sec_mask = i_item.byte_value[3:0];
                        end
                    end
                    default: begin
                        n_phase = r_phase;
                    end
                endcase

                // Open a section: find its first enabled word
                if (w_start) begin
                    n_offset = w_sec_off;
                    n_mask   = w_sec_mask;
                    n_byte   = 1'b0;
                    w_next   = next_clear(w_sec_mask, 3'd0);
                    if (w_next[2]) begin
                        n_widx    = '0;
                        w_sec_end = 1'b1;
                    end else begin
                        n_widx  = w_next[1:0];
                        n_phase = PH_DATA;
                    end
                end

                // Close a section: past-target check, then physical limit
                if (w_sec_end) begin
                    if ({1'b0, n_offset, 3'b000} > ({1'b0, i_cfg.target_offset} + 11'd8)) begin
                        n_phase = PH_DONE;
                        n_end   = efp_pkg::END_PAST_TGT;
                    end else if (n_count >= i_cfg.phys_limit) begin
                        n_phase = PH_DONE;
                        n_end   = efp_pkg::END_LIMIT;
                    end else begin
                        n_phase = PH_HDR;
                    end
                end
            end
        end

        // Report the end status once decoding has finished
        if (!i_item.req_type && n_phase == PH_DONE) begin
            o_result.done_res     = 1'b1;
            o_result.target_value = (n_capt == 8'hFF) ? 8'h00 : n_capt;
            o_result.end_cause    = n_end;
        end
    end

    // Hold decode state; advance on each processed request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HDR;
            r_hdr_hi <= '0;
            r_offset <= '0;
            r_mask   <= '0;
            r_widx   <= '0;
            r_byte   <= 1'b0;
            r_count  <= '0;
            r_capt   <= 8'hFF;
            r_end    <= efp_pkg::END_RUNNING;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_hdr_hi <= n_hdr_hi;
            r_offset <= n_offset;
            r_mask   <= n_mask;
            r_widx   <= n_widx;
            r_byte   <= n_byte;
            r_count  <= n_count;
            r_capt   <= n_capt;
            r_end    <= n_end;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/efp_checker.sv */
// Port-level checks for the packed fuse map decoder, bound to the top level.
`default_nettype none

module efp_checker #(
    parameter int MAP_BYTES = 320
) (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [31:0] m_axis_tdata,
    input wire logic [1:0]  m_axis_tuser
);

    // Stalled result holds
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // A finished result carries a cause; a running one carries none
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |->
            (m_axis_tuser[1] == (m_axis_tdata[28:26] != efp_pkg::END_RUNNING)))
        else $error("end cause disagrees with done flag");

    // Running results report no target value
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[1] |-> m_axis_tdata[25:18] == 8'h00)
        else $error("target value reported before done");

    // Writes stay inside the map; non-writes carry zero address and data
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |->
            (m_axis_tuser[0] ? ({1'b0, m_axis_tdata[9:0]} < 11'(MAP_BYTES))
                             : (m_axis_tdata[17:0] == 18'd0)))
        else $error("bad logical write");

endmodule

bind efuse_packed_map_decoder efp_checker #(
    .MAP_BYTES (MAP_BYTES)
) u_efp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
